// ===== rtl/wtok_pkg.sv =====
// Shared types, character constants and classification functions for the
// word tokenizer. Depends on nothing; used by all modules but the queue.
package wtok_pkg;

	localparam int TOK_LEN_W = 7;

	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_APOS   = 8'h27;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} back_st_t;

	// Control part of one queued command; the token characters travel beside it.
	typedef struct packed {
		logic                 is_write;
		logic                 has_tok;
		logic                 tok_ovf;
		logic                 has_mark;
		logic [7:0]           ch;
		logic [TOK_LEN_W-1:0] tok_len;
		logic [5:0]           entry_index;
		logic [3:0]           char_pos;
		logic [4:0]           entry_len;
	} cmd_ctl_t;

	function automatic logic [7:0] lower_ascii(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'd32;
		end
		return r;
	endfunction

	function automatic logic is_token_char(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
		       (c >= 8'h61 && c <= 8'h7A) || (c == CH_APOS);
	endfunction

	function automatic logic is_mark(input logic [7:0] c);
		return (c == CH_DOT) || (c == CH_COMMA) || (c == CH_QUEST) || (c == CH_BANG);
	endfunction

endpackage

// ===== rtl/word_tokenizer_vocab_lookup_unit.sv =====
// Operation: a vocabulary write is performed when the lookup engine takes it; a token or
// mark lookup is taken in the idle state, the entries are read one per cycle in the scan
// state (an overflowed token skips it), and the result word is loaded in the emit state.
// A word with both a token and a mark gives two results, each with its own scan.
// Reset: asynchronous; afterwards a clearing pass zeroes
// the entry lengths, during which input words are stalled. unk_id resets to zero.
module word_tokenizer_vocab_lookup_unit import wtok_pkg::*; #(
	parameter int VOCAB_SIZE    = 64,
	parameter int MAX_TOKEN_LEN = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       req_type,
	input  logic [7:0] ch,
	input  logic       end_of_text,
	input  logic [5:0] entry_index,
	input  logic [3:0] char_pos,
	input  logic [4:0] entry_len,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [5:0] token_id,
	output logic       is_unknown,
	output logic       last_of_run
);

	localparam int QW = $bits(cmd_ctl_t) + MAX_TOKEN_LEN * 8;

	logic [5:0] unk_id_q;
	logic       accept, q_push, q_pop, q_empty, q_full, clearing;
	cmd_ctl_t   push_ctl, head_ctl;
	logic [MAX_TOKEN_LEN-1:0][7:0] push_chars, head_chars;
	logic [QW-1:0] q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unk_id_q <= '0;
		end else if (cfg_we) begin
			unk_id_q <= cfg_wdata;
		end
	end

	assign in_stall = q_full || clearing;
	assign accept   = in_valid && !in_stall;

	wtok_front #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.req_type   (req_type),
		.ch         (ch),
		.end_of_text(end_of_text),
		.entry_index(entry_index),
		.char_pos   (char_pos),
		.entry_len  (entry_len),
		.push       (q_push),
		.push_ctl   (push_ctl),
		.push_chars (push_chars)
	);

	wtok_queue #(.WIDTH(QW)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data({push_ctl, push_chars}),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	assign {head_ctl, head_chars} = q_head;

	wtok_back #(.VOCAB_SIZE(VOCAB_SIZE), .MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.unk_id     (unk_id_q),
		.head_ctl   (head_ctl),
		.head_chars (head_chars),
		.q_empty    (q_empty),
		.pop        (q_pop),
		.clearing   (clearing),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.token_id   (token_id),
		.is_unknown (is_unknown),
		.last_of_run(last_of_run)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("command queue pushed while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("command queue popped while empty");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (in_stall && !q_push)) else $error("word taken during clearing pass");

endmodule

// ===== rtl/wtok_front.sv =====
// Front end: accepts words, lowercases and classifies them, builds the token
// in progress and pushes one command per word that has work. Uses wtok_pkg.
module wtok_front import wtok_pkg::*; #(
	parameter int MAX_TOKEN_LEN = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic                            req_type,
	input  logic [7:0]                      ch,
	input  logic                            end_of_text,
	input  logic [5:0]                      entry_index,
	input  logic [3:0]                      char_pos,
	input  logic [4:0]                      entry_len,
	output logic                            push,
	output cmd_ctl_t                        push_ctl,
	output logic [MAX_TOKEN_LEN-1:0][7:0]   push_chars
);

	localparam int LW = (MAX_TOKEN_LEN > 1) ? $clog2(MAX_TOKEN_LEN) : 1;
	localparam int TW = $clog2(MAX_TOKEN_LEN + 1);

	logic [MAX_TOKEN_LEN-1:0][7:0] buf_q, buf_nx;
	logic [TW-1:0]                 tok_len_q, len_nx;
	logic                          tok_ovf_q, ovf_nx;
	logic [7:0]                    lc;
	logic                          tc, mk, len_ok, grows, ends;

	always_comb begin
		lc     = lower_ascii(ch);
		tc     = is_token_char(ch);
		mk     = is_mark(ch);
		len_ok = 32'(tok_len_q) < MAX_TOKEN_LEN;
		grows  = tc && len_ok;
		len_nx = tok_len_q + TW'(grows);
		ovf_nx = tok_ovf_q | (tc & ~len_ok);
		ends   = (!tc || end_of_text) && (len_nx != '0);
		buf_nx = buf_q;
		if (grows) begin
			buf_nx[tok_len_q[LW-1:0]] = lc;
		end
	end

	always_comb begin
		push_ctl             = '0;
		push_chars           = buf_nx;
		push_ctl.entry_index = entry_index;
		push_ctl.char_pos    = char_pos;
		push_ctl.entry_len   = entry_len;
		if (req_type) begin
			push_ctl.is_write = 1'b1;
			push_ctl.ch       = lc;
			push              = accept;
		end else begin
			push_ctl.has_tok  = ends;
			push_ctl.tok_ovf  = ovf_nx;
			push_ctl.has_mark = mk;
			push_ctl.ch       = ch;
			push_ctl.tok_len  = TOK_LEN_W'(len_nx);
			push              = accept && (ends || mk);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_len_q <= '0;
			tok_ovf_q <= 1'b0;
		end else if (accept && !req_type) begin
			if (ends) begin
				tok_len_q <= '0;
				tok_ovf_q <= 1'b0;
			end else begin
				tok_len_q <= len_nx;
				tok_ovf_q <= ovf_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !req_type) begin
			buf_q <= buf_nx;
		end
	end

endmodule

// ===== rtl/wtok_queue.sv =====
// Two-entry command queue between the front end and the lookup engine.
// Depends on nothing but its width parameter.
module wtok_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             empty,
	output logic             full
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/wtok_back.sv =====
// Lookup engine: owns the vocabulary memories, performs entry writes and scans
// the entries one per cycle for each lookup (an overflowed token skips the scan),
// and holds the output word register. Uses wtok_pkg.
module wtok_back import wtok_pkg::*; #(
	parameter int VOCAB_SIZE    = 64,
	parameter int MAX_TOKEN_LEN = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [5:0]                    unk_id,
	input  cmd_ctl_t                      head_ctl,
	input  logic [MAX_TOKEN_LEN-1:0][7:0] head_chars,
	input  logic                          q_empty,
	output logic                          pop,
	output logic                          clearing,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [5:0]                    token_id,
	output logic                          is_unknown,
	output logic                          last_of_run
);

	localparam int VW = (VOCAB_SIZE > 1) ? $clog2(VOCAB_SIZE) : 1;
	localparam int LW = (MAX_TOKEN_LEN > 1) ? $clog2(MAX_TOKEN_LEN) : 1;

	logic [MAX_TOKEN_LEN-1:0][7:0] vocab_mem [VOCAB_SIZE];
	logic [4:0]                    len_mem   [VOCAB_SIZE];

	back_st_t st_q, st_nx;
	logic [VW-1:0] clr_cnt_q;
	logic [VW:0]   cnt_q;
	logic          phase_q;
	logic          valid_s1;
	logic [VW-1:0] idx_s1;
	logic [MAX_TOKEN_LEN-1:0][7:0] row_s1;
	logic [4:0]    rlen_s1;
	logic [5:0]    res_id_q;
	logic          res_unk_q;
	logic          out_valid_q, out_unk_q, out_last_q;
	logic [5:0]    out_id_q;

	logic [MAX_TOKEN_LEN-1:0][7:0] key_chars;
	logic [TOK_LEN_W-1:0]          key_len;
	logic match, hit, miss_end, last_res, out_free, issue;
	logic vocab_we, start_scan, load_out, take_lookup, ovf_direct;
	logic idx_ok, pos_ok, len_we;
	logic [VW-1:0] wr_addr, len_wa;
	logic [4:0]    len_wd;

	always_comb begin
		key_chars    = '0;
		key_chars[0] = head_ctl.ch;
		key_len      = TOK_LEN_W'(1);
		if (!phase_q) begin
			key_chars = head_chars;
			key_len   = head_ctl.tok_len;
		end
	end

	// Characters past the token length are don't-care on both sides.
	always_comb begin
		match = (TOK_LEN_W'(rlen_s1) == key_len);
		for (int k = 0; k < MAX_TOKEN_LEN; k++) begin
			if (32'(k) < 32'(key_len) && row_s1[k] != key_chars[k]) begin
				match = 1'b0;
			end
		end
	end

	assign hit      = valid_s1 && match;
	assign miss_end = valid_s1 && !match && (idx_s1 == VW'(VOCAB_SIZE - 1));
	assign last_res = phase_q || !head_ctl.has_mark;
	assign out_free = !out_valid_q || !out_stall;
	assign issue    = (st_q == ST_SCAN) && (32'(cnt_q) < VOCAB_SIZE);
	assign idx_ok   = 32'(head_ctl.entry_index) < VOCAB_SIZE;
	assign pos_ok   = 32'(head_ctl.char_pos) < MAX_TOKEN_LEN;
	assign wr_addr  = VW'(head_ctl.entry_index);

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			ST_CLEAR: begin
				if (clr_cnt_q == VW'(VOCAB_SIZE - 1)) begin
					st_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!q_empty && !head_ctl.is_write) begin
					st_nx = (head_ctl.has_tok && head_ctl.tok_ovf) ? ST_EMIT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit || miss_end) begin
					st_nx = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					st_nx = last_res ? ST_IDLE : ST_SCAN;
				end
			end
			default: st_nx = ST_CLEAR;
		endcase
	end

	always_comb begin
		vocab_we    = 1'b0;
		take_lookup = 1'b0;
		ovf_direct  = 1'b0;
		start_scan  = 1'b0;
		load_out    = 1'b0;
		pop         = 1'b0;
		clearing    = 1'b0;
		unique case (st_q)
			ST_CLEAR: clearing = 1'b1;
			ST_IDLE: begin
				if (!q_empty) begin
					if (head_ctl.is_write) begin
						vocab_we = 1'b1;
						pop      = 1'b1;
					end else begin
						take_lookup = 1'b1;
						ovf_direct  = head_ctl.has_tok && head_ctl.tok_ovf;
						start_scan  = !ovf_direct;
					end
				end
			end
			ST_SCAN: ;
			ST_EMIT: begin
				if (out_free) begin
					load_out   = 1'b1;
					pop        = last_res;
					start_scan = !last_res;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		len_we = 1'b0;
		len_wa = wr_addr;
		len_wd = head_ctl.entry_len;
		if (clearing) begin
			len_we = 1'b1;
			len_wa = clr_cnt_q;
			len_wd = '0;
		end else if (vocab_we && idx_ok) begin
			len_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem[len_wa] <= len_wd;
		end
		if (vocab_we && idx_ok && pos_ok) begin
			vocab_mem[wr_addr][LW'(head_ctl.char_pos)] <= head_ctl.ch;
		end
		row_s1  <= vocab_mem[cnt_q[VW-1:0]];
		rlen_s1 <= len_mem[cnt_q[VW-1:0]];
		idx_s1  <= cnt_q[VW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			clr_cnt_q   <= '0;
			cnt_q       <= '0;
			phase_q     <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (clearing) begin
				clr_cnt_q <= clr_cnt_q + VW'(1);
			end
			if (take_lookup) begin
				phase_q <= !head_ctl.has_tok;
			end else if (start_scan) begin
				phase_q <= 1'b1;
			end
			if (start_scan) begin
				cnt_q    <= '0;
				valid_s1 <= 1'b0;
			end else begin
				valid_s1 <= issue;
				if (issue) begin
					cnt_q <= cnt_q + (VW+1)'(1);
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ovf_direct || ((st_q == ST_SCAN) && miss_end)) begin
			res_id_q  <= unk_id;
			res_unk_q <= 1'b1;
		end else if ((st_q == ST_SCAN) && hit) begin
			res_id_q  <= 6'(idx_s1);
			res_unk_q <= 1'b0;
		end
		if (load_out) begin
			out_id_q   <= res_id_q;
			out_unk_q  <= res_unk_q;
			out_last_q <= last_res;
		end
	end

	assign out_valid   = out_valid_q;
	assign token_id    = out_id_q;
	assign is_unknown  = out_unk_q;
	assign last_of_run = out_last_q;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for word_tokenizer_vocab_lookup_unit: a directed table, then random
// vocabulary writes and text, checked against an in-bench tokenizer predictor.
// Depends on rtl/wtok_pkg.sv and rtl/word_tokenizer_vocab_lookup_unit.sv.
module tb_top;
	import wtok_pkg::*;

	localparam int NENT = 64;
	localparam int MAXLEN = 16;
	localparam int DRAIN_CYCLES = 90;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam int HOLD_CYCLES = 400;
	localparam bit REQ_TEXT = 1'b0;
	localparam bit REQ_VOCAB = 1'b1;

	typedef struct {
		bit         req;
		logic [7:0] c;
		bit         eot;
		logic [5:0] idx;
		logic [3:0] pos;
		logic [4:0] len;
	} word_t;

	typedef struct {
		logic [5:0] id;
		bit         unk;
		bit         last;
	} tok_res_t;

	// Directed row: nres < 0 means the results come from the predictor.
	typedef struct {
		word_t    w;
		int       nres;
		tok_res_t r0;
		tok_res_t r1;
	} drow_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [5:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = 1'b0;
	logic [7:0] ch = '0;
	logic end_of_text = 1'b0;
	logic [5:0] entry_index = '0;
	logic [3:0] char_pos = '0;
	logic [4:0] entry_len = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [5:0] token_id;
	logic is_unknown;
	logic last_of_run;

	word_tokenizer_vocab_lookup_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .req_type(req_type), .ch(ch),
		.end_of_text(end_of_text), .entry_index(entry_index), .char_pos(char_pos),
		.entry_len(entry_len), .out_valid(out_valid), .out_stall(out_stall),
		.token_id(token_id), .is_unknown(is_unknown), .last_of_run(last_of_run)
	);

	// Predictor state.
	logic [7:0] vchar [NENT][MAXLEN];
	bit         vwritten [NENT][MAXLEN];
	logic [4:0] vlen [NENT];
	logic [7:0] tbuf [MAXLEN];
	int         tlen;
	bit         tovf;
	logic [5:0] unk_reg;

	tok_res_t pending_tokens[$];
	int errors = 0;
	longint cycles = 0;
	int s_idle = 0;
	int r_idle = 0;
	bit hold_go = 1'b0;
	int hold_left = 0;
	int sent = 0;

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** word_tokenizer_vocab_lookup_unit: FAILED **");
			$finish;
		end
	end

	// Receiver: random stalls plus an occasional long hold-off.
	always @(posedge clk) begin
		if (hold_go && hold_left == 0) begin
			hold_left <= HOLD_CYCLES;
			hold_go <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
		out_stall <= (hold_left > 1) || ($urandom_range(99) < r_idle);
	end

	always @(posedge clk) begin
		tok_res_t e;
		if (out_valid && !out_stall) begin
			if (pending_tokens.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: id %0d unk %0b last %0b",
						token_id, is_unknown, last_of_run);
			end else begin
				e = pending_tokens.pop_front();
				if (token_id !== e.id || is_unknown !== e.unk || last_of_run !== e.last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected id %0d unk %0b last %0b, got %0d %0b %0b",
							e.id, e.unk, e.last, token_id, is_unknown, last_of_run);
				end
			end
		end
	end

	function automatic void expect_res(tok_res_t r);
		pending_tokens.insert(pending_tokens.size(), r);
	endfunction

	function automatic logic [7:0] fold_case(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic bit word_char(logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
		       (c >= "a" && c <= "z") || c == CH_APOS;
	endfunction

	function automatic bit punct_mark(logic [7:0] c);
		return c == CH_DOT || c == CH_COMMA || c == CH_QUEST || c == CH_BANG;
	endfunction

	// Lowest entry whose length and characters equal the token.
	function automatic bit match_entry(int n, logic [7:0] t [MAXLEN], output logic [5:0] id);
		bit ok;
		id = unk_reg;
		for (int i = 0; i < NENT; i++) begin
			if (vlen[i] == n) begin
				ok = 1'b1;
				for (int k = 0; k < n; k++)
					if (vchar[i][k] != t[k]) ok = 1'b0;
				if (ok) begin
					id = 6'(i);
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	task automatic predict_word(word_t w, bit keep);
		tok_res_t r [2];
		logic [7:0] one [MAXLEN];
		logic [5:0] id;
		bit found;
		bit tc;
		int n;
		n = 0;
		if (w.req == REQ_VOCAB) begin
			vlen[w.idx] = w.len;
			vchar[w.idx][w.pos] = fold_case(w.c);
			vwritten[w.idx][w.pos] = 1'b1;
			return;
		end
		tc = word_char(w.c);
		if (tc) begin
			if (tlen < MAXLEN) begin
				tbuf[tlen] = fold_case(w.c);
				tlen++;
			end else begin
				tovf = 1'b1;
			end
		end
		if ((!tc || w.eot) && tlen > 0) begin
			found = 1'b0;
			id = unk_reg;
			if (!tovf) found = match_entry(tlen, tbuf, id);
			r[n] = '{found ? id : unk_reg, !found, 1'b0};
			n++;
			tlen = 0;
			tovf = 1'b0;
		end
		if (punct_mark(w.c)) begin
			one[0] = w.c;
			found = match_entry(1, one, id);
			r[n] = '{found ? id : unk_reg, !found, 1'b0};
			n++;
		end
		if (n > 0) r[n-1].last = 1'b1;
		if (keep)
			for (int k = 0; k < n; k++) expect_res(r[k]);
	endtask

	task automatic send_word(word_t w, bit keep);
		req_type <= w.req;
		ch <= w.c;
		end_of_text <= w.eot;
		entry_index <= w.idx;
		char_pos <= w.pos;
		entry_len <= w.len;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_word(w, keep);
		sent++;
		if ($urandom_range(99) < s_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain;
		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_unk(logic [5:0] v);
		in_valid <= 1'b0;
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		unk_reg = v;
	endtask

	function automatic logic [7:0] rand_word_char();
		case ($urandom_range(3))
			0: return 8'("a" + $urandom_range(25));
			1: return 8'("A" + $urandom_range(25));
			2: return 8'("0" + $urandom_range(9));
			default: return CH_APOS;
		endcase
	endfunction

	function automatic logic [7:0] rand_separator();
		logic [7:0] c;
		case ($urandom_range(4))
			0: return 8'h20;
			1: begin
				case ($urandom_range(3))
					0: return CH_DOT;
					1: return CH_COMMA;
					2: return CH_QUEST;
					default: return CH_BANG;
				endcase
			end
			2: return 8'($urandom_range(128, 255));
			default: begin
				do c = 8'($urandom_range(255)); while (word_char(c));
				return c;
			end
		endcase
	endfunction

	function automatic word_t text_word(logic [7:0] c, bit eot);
		word_t w;
		w.req = REQ_TEXT;
		w.c = c;
		w.eot = eot;
		w.idx = 6'($urandom);
		w.pos = 4'($urandom);
		w.len = 5'($urandom_range(16));
		return w;
	endfunction

	// One random burst: a whole vocabulary entry, a lone write, or a piece of text.
	task automatic random_burst();
		word_t w;
		logic [7:0] c;
		int kind, n, e, p;
		bit eot_done;
		kind = $urandom_range(99);
		if (kind < 10) begin
			n = ($urandom_range(9) == 0) ? MAXLEN : $urandom_range(1, 6);
			e = $urandom_range(NENT - 1);
			for (int k = 0; k < n; k++) begin
				if (n == 1 && $urandom_range(1)) c = rand_separator();
				else c = rand_word_char();
				w = '{REQ_VOCAB, c, 1'($urandom), 6'(e), 4'(k), 5'(n)};
				send_word(w, 1'b1);
			end
		end else if (kind < 15) begin
			// Lone write: its length never exposes a character that was never written.
			e = $urandom_range(NENT - 1);
			w = '{REQ_VOCAB, 8'($urandom), 1'($urandom), 6'(e), 4'($urandom), 5'd0};
			p = 0;
			while (p < MAXLEN && (vwritten[e][p] || p == w.pos)) p++;
			if (p > 0 && $urandom_range(1)) w.len = 5'($urandom_range(1, p));
			send_word(w, 1'b1);
		end else begin
			eot_done = 1'b0;
			e = -1;
			n = $urandom_range(1, 5);
			if (kind < 20) begin
				n = $urandom_range(17, 20);
			end else if (kind < 65) begin
				for (int t = 0; t < 8 && e < 0; t++) begin
					p = $urandom_range(NENT - 1);
					if (vlen[p] >= 1 && vlen[p] <= MAXLEN) e = p;
				end
				if (e >= 0) n = int'(vlen[e]);
			end
			if (kind >= 95) n = 0;
			for (int k = 0; k < n; k++) begin
				if (e >= 0) begin
					c = vchar[e][k];
					if (c >= "a" && c <= "z" && $urandom_range(1)) c = c - 8'd32;
				end else begin
					c = rand_word_char();
				end
				eot_done = (k == n - 1) && ($urandom_range(99) < 15);
				send_word(text_word(c, eot_done), 1'b1);
			end
			if (!eot_done)
				send_word(text_word(rand_separator(), $urandom_range(9) == 0), 1'b1);
		end
	endtask

	task automatic run_phase(int target, bit squeeze);
		int start;
		bit paused;
		start = sent;
		paused = 1'b0;
		while (sent - start < target) begin
			random_burst();
			if (!paused && sent - start > target / 3) begin
				paused = 1'b1;
				if (squeeze) begin
					hold_go <= 1'b1;
				end else begin
					in_valid <= 1'b0;
					drain();
				end
			end
		end
	endtask

	drow_t dtab [$];

	function automatic void add_row(drow_t d);
		dtab.insert(dtab.size(), d);
	endfunction

	function automatic drow_t vrow(int e, int p, logic [7:0] c, int n);
		drow_t d;
		d.w = '{REQ_VOCAB, c, 1'b0, 6'(e), 4'(p), 5'(n)};
		d.nres = -1;
		return d;
	endfunction

	function automatic drow_t trow(logic [7:0] c, bit eot, int nr, tok_res_t a, tok_res_t b);
		drow_t d;
		d.w = '{REQ_TEXT, c, eot, 6'd0, 4'd0, 5'd0};
		d.nres = nr;
		d.r0 = a;
		d.r1 = b;
		return d;
	endfunction

	initial begin
		tok_res_t none;
		none = '{6'd0, 1'b0, 1'b0};
		for (int i = 0; i < NENT; i++) begin
			vlen[i] = '0;
			for (int k = 0; k < MAXLEN; k++) begin
				vchar[i][k] = '0;
				vwritten[i][k] = 1'b0;
			end
		end
		tlen = 0;
		tovf = 1'b0;
		unk_reg = '0;

		// Empty vocabulary straight after reset: everything is unknown with id zero.
		add_row(trow("Z", 1'b0, 0, none, none));
		add_row(trow(8'h20, 1'b0, 1, '{6'd0, 1'b1, 1'b1}, none));
		add_row(trow(CH_DOT, 1'b0, 1, '{6'd0, 1'b1, 1'b1}, none));
		add_row(vrow(0, 0, "<", 5));
		add_row(vrow(0, 1, "U", 5));
		add_row(vrow(0, 2, "n", 5));
		add_row(vrow(0, 3, "K", 5));
		add_row(vrow(0, 4, ">", 5));
		add_row(vrow(63, 0, CH_DOT, 1));
		add_row(vrow(1, 0, "H", 2));
		add_row(vrow(1, 1, "I", 2));
		// A zero-length entry must never match.
		add_row(vrow(5, 0, "x", 0));
		add_row(trow("H", 1'b0, 0, none, none));
		add_row(trow("i", 1'b0, 0, none, none));
		add_row(trow(CH_DOT, 1'b0, 2, '{6'd1, 1'b0, 1'b0}, '{6'd63, 1'b0, 1'b1}));
		add_row(trow("x", 1'b0, 0, none, none));
		add_row(trow(8'hFF, 1'b0, 1, '{6'd0, 1'b1, 1'b1}, none));
		add_row(trow("h", 1'b0, 0, none, none));
		add_row(trow("I", 1'b1, 1, '{6'd1, 1'b0, 1'b1}, none));
		add_row(trow(CH_BANG, 1'b0, 1, '{6'd0, 1'b1, 1'b1}, none));
		add_row(trow(CH_APOS, 1'b0, 0, none, none));
		add_row(trow("9", 1'b0, 0, none, none));
		add_row(trow(CH_COMMA, 1'b0, 2, '{6'd0, 1'b1, 1'b0}, '{6'd0, 1'b1, 1'b1}));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dtab[i]) begin
			send_word(dtab[i].w, dtab[i].nres < 0);
			if (dtab[i].nres > 0) expect_res(dtab[i].r0);
			if (dtab[i].nres > 1) expect_res(dtab[i].r1);
		end

		set_unk(6'd63);
		s_idle = 19;
		r_idle = 63;
		run_phase(510, 1'b0);
		set_unk(6'($urandom_range(1, 62)));
		s_idle = 63;
		r_idle = 19;
		run_phase(510, 1'b0);
		set_unk(6'd0);
		s_idle = 0;
		r_idle = 0;
		run_phase(510, 1'b1);

		in_valid <= 1'b0;
		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		errors += pending_tokens.size();
		if (errors == 0) begin
			$display("** word_tokenizer_vocab_lookup_unit: PASSED **");
		end else begin
			$display("** word_tokenizer_vocab_lookup_unit: FAILED **");
		end
		$finish;
	end

endmodule
